// ===== hdl/hsa_pkg.sv =====
// ----------------------------------------------------------------------------
// Heatmap splat accumulator package
// Shared word types, opcodes, arithmetic constants and the command/status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package hsa_pkg;

	// field widths
	localparam int OP_W   = 2;
	localparam int POS_W  = 8;
	localparam int COL_W  = 8;
	localparam int HEAT_W = 24;

	// opcodes
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
	localparam logic [OP_W-1:0] OP_SPLAT = 2'd1;
	localparam logic [OP_W-1:0] OP_READ  = 2'd2;
	localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

	// heat arithmetic
	localparam logic [HEAT_W-1:0] HEAT_MAX   = 24'hFFFFFF;
	localparam logic [HEAT_W-1:0] CENTRE_ADD = 24'd50;
	localparam int                SPREAD_NUM = 800;
	localparam logic [COL_W-1:0]  COL_MAX    = 8'd255;

	// spread divider: quotient of 800 needs 10 bits, squared distance of a
	// radius up to 31 needs 11 bits
	localparam int QUO_W = 10;
	localparam int D2_W  = 11;
	// window offset (radius up to 31) and window coordinate (-31..286)
	localparam int OFS_W = 6;
	localparam int CRD_W = 10;

	// input word
	typedef struct packed {
		logic [OP_W-1:0]  opcode;
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
	} item_t;

	// result word
	typedef struct packed {
		logic [COL_W-1:0]  red;
		logic [COL_W-1:0]  green;
		logic [COL_W-1:0]  blue;
		logic              cell_nonzero;
		logic [HEAT_W-1:0] cell_heat;
		logic [HEAT_W-1:0] peak_value;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic load;       // capture the input word
		logic sweep;      // write zero at the sweep address and advance
		logic peak_clr;   // clear the peak
		logic win_init;   // reset window offsets to the corner
		logic win_step;   // issue one window cell and advance
		logic rd_cell;    // read the addressed cell
		logic heat_ld;    // capture read heat
		logic col_start;  // start the colour divider
		logic out_ld;     // load the result register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic sweep_last;
		logic win_last;
		logic pipe_empty;
		logic col_done;
	} sts_t;

endpackage

// ===== hdl/hsa_colour.sv =====
// ----------------------------------------------------------------------------
// Heatmap colour unit
// Maps a heat value against the peak to a blue-green-red colour with an
// 8-step restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hsa_colour (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [hsa_pkg::HEAT_W-1:0]       heat,
	input  logic [hsa_pkg::HEAT_W-1:0]       peak,
	output logic                             done,
	output logic [hsa_pkg::COL_W-1:0]        red,
	output logic [hsa_pkg::COL_W-1:0]        green,
	output logic [hsa_pkg::COL_W-1:0]        blue
);

	// numerator holds heat*510 at most
	localparam int NUM_W = hsa_pkg::HEAT_W + 9;
	localparam int CNT_W = $clog2(hsa_pkg::COL_W);

	localparam logic [1:0] MD_RED  = 2'd0;
	localparam logic [1:0] MD_LOW  = 2'd1;
	localparam logic [1:0] MD_HIGH = 2'd2;

	logic [1:0]                   mode_q, mode_d;
	logic [NUM_W-1:0]             n_q, n_d;
	logic [hsa_pkg::HEAT_W-1:0]   d_q, d_d;
	logic [hsa_pkg::COL_W-1:0]    q_q;
	logic [CNT_W-1:0]             cnt_q;
	logic                         run_q;
	logic                         done_q;
	logic [hsa_pkg::HEAT_W-1:0]   diff;
	logic [NUM_W-1:0]             trial;
	logic                         fits;

	// pick the colour band and set up the division
	always_comb begin
		diff   = peak - heat;
		mode_d = MD_RED;
		n_d    = '0;
		d_d    = hsa_pkg::HEAT_W'(1);
		if (heat > peak) begin
			mode_d = MD_RED;
		end else if ({heat, 1'b0} <= {1'b0, peak}) begin
			mode_d = MD_LOW;
			// zero peak here means zero heat: quotient stays zero
			if (peak != '0) begin
				n_d = {heat, 9'd0} - NUM_W'({heat, 1'b0});
				d_d = peak;
			end
		end else begin
			mode_d = MD_HIGH;
			n_d    = NUM_W'({diff, 8'd0}) - NUM_W'(diff);
			d_d    = heat;
		end
	end

	// one restoring step
	assign trial = NUM_W'(d_q) << cnt_q;
	assign fits  = (n_q >= trial);

	// divider control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(hsa_pkg::COL_W - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// divider data
	always_ff @(posedge clk) begin
		if (start) begin
			mode_q <= mode_d;
			n_q    <= n_d;
			d_q    <= d_d;
			q_q    <= '0;
		end else if (run_q && fits) begin
			n_q        <= n_q - trial;
			q_q[cnt_q] <= 1'b1;
		end
	end

	// colour from band and quotient
	always_comb begin
		unique case (mode_q)
			MD_RED: begin
				red   = hsa_pkg::COL_MAX;
				green = '0;
				blue  = '0;
			end
			MD_LOW: begin
				red   = '0;
				green = q_q;
				blue  = hsa_pkg::COL_MAX - q_q;
			end
			MD_HIGH: begin
				red   = hsa_pkg::COL_MAX - q_q;
				green = q_q;
				blue  = '0;
			end
			default: begin
				red   = '0;
				green = '0;
				blue  = '0;
			end
		endcase
	end

	assign done = done_q;

endmodule

// ===== hdl/hsa_datapath.sv =====
// ----------------------------------------------------------------------------
// Heatmap datapath
// Heat grid memory, clearing sweep, window walk with a pipelined spread
// divider and read-modify-write stage, peak register, colour unit and the
// result register.
// ----------------------------------------------------------------------------
module hsa_datapath #(
	parameter int GRID_SIZE    = 256,
	parameter int SPLAT_RADIUS = 15
) (
	input  logic             clk,
	input  logic             arst_n,
	input  hsa_pkg::item_t   item,
	input  hsa_pkg::cmd_t    cmd,
	output hsa_pkg::sts_t    sts,
	output hsa_pkg::result_t result
);

	localparam int DEPTH  = GRID_SIZE * GRID_SIZE;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int SQ_W   = 2 * hsa_pkg::OFS_W;
	localparam int TRY_W  = hsa_pkg::QUO_W + hsa_pkg::D2_W;
	localparam int HW     = hsa_pkg::HEAT_W;

	localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);
	localparam logic [ADDR_W-1:0] GRID_A    = ADDR_W'(GRID_SIZE);
	localparam logic signed [hsa_pkg::OFS_W-1:0] OFS_LO = hsa_pkg::OFS_W'(-SPLAT_RADIUS);
	localparam logic signed [hsa_pkg::OFS_W-1:0] OFS_HI = hsa_pkg::OFS_W'(SPLAT_RADIUS);

	// one spread divider stage
	typedef struct packed {
		logic                         v;
		logic                         ctr;
		logic [ADDR_W-1:0]            addr;
		logic [hsa_pkg::QUO_W-1:0]    rem;
		logic [hsa_pkg::D2_W-1:0]     den;
		logic [hsa_pkg::QUO_W-1:0]    quo;
	} dstg_t;

	function automatic logic in_grid(input logic [hsa_pkg::CRD_W-1:0] c);
		in_grid = !c[hsa_pkg::CRD_W-1] && (int'(c[hsa_pkg::CRD_W-2:0]) < GRID_SIZE);
	endfunction

	function automatic dstg_t div_step(input dstg_t a, input int b);
		logic [TRY_W-1:0] sh;
		logic [TRY_W-1:0] rx;
		dstg_t            r;
		sh = TRY_W'(a.den) << b;
		rx = TRY_W'(a.rem);
		r  = a;
		if (rx >= sh) begin
			r.rem    = hsa_pkg::QUO_W'(rx - sh);
			r.quo[b] = 1'b1;
		end
		div_step = r;
	endfunction

	// item registers
	logic [hsa_pkg::OP_W-1:0]   op_q;
	logic [hsa_pkg::POS_W-1:0]  x_q, y_q;
	logic [ADDR_W-1:0]          item_addr_q;
	logic                       item_in_q;

	// sweep and window counters
	logic [ADDR_W-1:0]                  clr_q;
	logic signed [hsa_pkg::OFS_W-1:0]   dx_q, dy_q;

	// window pipeline
	logic                         v_s1, ctr_s1;
	logic [hsa_pkg::CRD_W-1:0]    i_s1, j_s1;
	logic [SQ_W-1:0]              sqx_s1, sqy_s1;
	logic                         v_s2, ctr_s2;
	logic [ADDR_W-1:0]            addr_s2;
	logic [hsa_pkg::D2_W-1:0]     d2_s2;
	dstg_t                        div_in;
	dstg_t                        div_s3 [hsa_pkg::QUO_W];
	dstg_t                        dlast;
	logic [hsa_pkg::QUO_W-1:0]    div_v;
	logic                         v_s4, ctr_s4;
	logic [ADDR_W-1:0]            addr_s4;
	logic [HW-1:0]                add_s4;

	// window coordinates of the current offset
	logic [hsa_pkg::CRD_W-1:0]    i_d, j_d;
	logic [SQ_W-1:0]              sqx_d, sqy_d;

	// memory port and heat
	logic [HW-1:0]                mem [DEPTH];
	logic [HW-1:0]                mem_rd_q;
	logic [ADDR_W-1:0]            ra, wa;
	logic [HW-1:0]                wd;
	logic                         we;
	logic [HW:0]                  sum;
	logic [HW-1:0]                sat;
	logic [HW-1:0]                peak_q;
	logic [HW-1:0]                heat_q;
	hsa_pkg::result_t             result_q;

	// colour unit results
	logic                         col_done;
	logic [hsa_pkg::COL_W-1:0]    col_r, col_g, col_b;

	// capture the input word and its cell address
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q        <= item.opcode;
			x_q         <= item.pos_x;
			y_q         <= item.pos_y;
			item_addr_q <= ADDR_W'(item.pos_x) * GRID_A + ADDR_W'(item.pos_y);
			item_in_q   <= (int'(item.pos_x) < GRID_SIZE) && (int'(item.pos_y) < GRID_SIZE);
		end
	end

	// clearing sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.sweep) begin
			clr_q <= (clr_q == ADDR_LAST) ? '0 : clr_q + ADDR_W'(1);
		end
	end

	// window offset walk, row of dy inside dx
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dx_q <= OFS_LO;
			dy_q <= OFS_LO;
		end else if (cmd.win_init) begin
			dx_q <= OFS_LO;
			dy_q <= OFS_LO;
		end else if (cmd.win_step) begin
			if (dy_q == OFS_HI) begin
				dy_q <= OFS_LO;
				dx_q <= dx_q + hsa_pkg::OFS_W'(1);
			end else begin
				dy_q <= dy_q + hsa_pkg::OFS_W'(1);
			end
		end
	end

	// stage 1 inputs: coordinates and squared offsets
	always_comb begin
		i_d   = hsa_pkg::CRD_W'(x_q)
		      + {{(hsa_pkg::CRD_W - hsa_pkg::OFS_W){dx_q[hsa_pkg::OFS_W-1]}}, dx_q};
		j_d   = hsa_pkg::CRD_W'(y_q)
		      + {{(hsa_pkg::CRD_W - hsa_pkg::OFS_W){dy_q[hsa_pkg::OFS_W-1]}}, dy_q};
		sqx_d = SQ_W'(dx_q * dx_q);
		sqy_d = SQ_W'(dy_q * dy_q);
	end

	// stage 2 feeds the spread divider
	always_comb begin
		div_in     = '0;
		div_in.v   = v_s2;
		div_in.ctr = ctr_s2;
		div_in.addr = addr_s2;
		div_in.rem = hsa_pkg::QUO_W'(hsa_pkg::SPREAD_NUM);
		div_in.den = d2_s2;
	end

	// window pipeline: coordinates, address, divider, read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			ctr_s1 <= 1'b0;
			i_s1   <= '0;
			j_s1   <= '0;
			sqx_s1 <= '0;
			sqy_s1 <= '0;
			v_s2   <= 1'b0;
			ctr_s2 <= 1'b0;
			addr_s2 <= '0;
			d2_s2  <= '0;
			for (int k = 0; k < hsa_pkg::QUO_W; k++) begin
				div_s3[k] <= '0;
			end
			v_s4   <= 1'b0;
			ctr_s4 <= 1'b0;
			addr_s4 <= '0;
			add_s4 <= '0;
		end else begin
			v_s1   <= cmd.win_step;
			ctr_s1 <= (dx_q == '0) && (dy_q == '0);
			i_s1   <= i_d;
			j_s1   <= j_d;
			sqx_s1 <= sqx_d;
			sqy_s1 <= sqy_d;

			// cells off the grid leave the pipeline here
			v_s2    <= v_s1 && in_grid(i_s1) && in_grid(j_s1);
			ctr_s2  <= ctr_s1;
			addr_s2 <= ADDR_W'(i_s1[hsa_pkg::CRD_W-2:0]) * GRID_A
			         + ADDR_W'(j_s1[hsa_pkg::CRD_W-2:0]);
			d2_s2   <= hsa_pkg::D2_W'(sqx_s1 + sqy_s1);

			// one quotient bit per stage, most significant first
			div_s3[0] <= div_step(div_in, hsa_pkg::QUO_W - 1);
			for (int k = 1; k < hsa_pkg::QUO_W; k++) begin
				div_s3[k] <= div_step(div_s3[k-1], hsa_pkg::QUO_W - 1 - k);
			end

			v_s4    <= dlast.v;
			ctr_s4  <= dlast.ctr;
			addr_s4 <= dlast.addr;
			add_s4  <= dlast.ctr ? hsa_pkg::CENTRE_ADD : HW'(dlast.quo);
		end
	end

	assign dlast = div_s3[hsa_pkg::QUO_W-1];

	always_comb begin
		for (int k = 0; k < hsa_pkg::QUO_W; k++) begin
			div_v[k] = div_s3[k].v;
		end
	end

	// saturating add and memory port selection
	always_comb begin
		sum = {1'b0, mem_rd_q} + {1'b0, add_s4};
		sat = sum[HW] ? hsa_pkg::HEAT_MAX : sum[HW-1:0];
		ra  = cmd.rd_cell ? item_addr_q : dlast.addr;
		we  = cmd.sweep || v_s4;
		wa  = cmd.sweep ? clr_q : addr_s4;
		wd  = cmd.sweep ? '0 : sat;
	end

	// heat grid
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		mem_rd_q <= mem[ra];
	end

	// peak follows the centre cell after its update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= '0;
		end else if (cmd.peak_clr) begin
			peak_q <= '0;
		end else if (v_s4 && ctr_s4 && (sat > peak_q)) begin
			peak_q <= sat;
		end
	end

	// heat of the read cell, zero off the grid
	always_ff @(posedge clk) begin
		if (cmd.heat_ld) begin
			heat_q <= item_in_q ? mem_rd_q : '0;
		end
	end

	hsa_colour u_colour (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.col_start),
		.heat   (heat_q),
		.peak   (peak_q),
		.done   (col_done),
		.red    (col_r),
		.green  (col_g),
		.blue   (col_b)
	);

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			result_q.peak_value <= peak_q;
			if (op_q == hsa_pkg::OP_READ) begin
				result_q.red          <= col_r;
				result_q.green        <= col_g;
				result_q.blue         <= col_b;
				result_q.cell_nonzero <= (heat_q != '0);
				result_q.cell_heat    <= heat_q;
			end else begin
				result_q.red          <= '0;
				result_q.green        <= '0;
				result_q.blue         <= '0;
				result_q.cell_nonzero <= 1'b0;
				result_q.cell_heat    <= '0;
			end
		end
	end

	// status back to the controller
	always_comb begin
		sts.sweep_last = (clr_q == ADDR_LAST);
		sts.win_last   = (dx_q == OFS_HI) && (dy_q == OFS_HI);
		sts.pipe_empty = !v_s1 && !v_s2 && (div_v == '0) && !v_s4;
		sts.col_done   = col_done;
	end

	assign result = result_q;

endmodule

// ===== hdl/hsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// Heatmap controller
// Sequences the clearing sweep, the window walk, the cell read and the
// colour division, and raises the result strobe.
// ----------------------------------------------------------------------------
module hsa_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [hsa_pkg::OP_W-1:0]   op,
	input  hsa_pkg::sts_t              sts,
	output logic                       busy,
	output logic                       done,
	output hsa_pkg::cmd_t              cmd
);

	localparam logic [3:0] ST_INIT  = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_CLEAR = 4'd2;
	localparam logic [3:0] ST_WIN   = 4'd3;
	localparam logic [3:0] ST_DRAIN = 4'd4;
	localparam logic [3:0] ST_RD0   = 4'd5;
	localparam logic [3:0] ST_RD1   = 4'd6;
	localparam logic [3:0] ST_COL0  = 4'd7;
	localparam logic [3:0] ST_COL   = 4'd8;
	localparam logic [3:0] ST_FIN   = 4'd9;

	logic [3:0] state_q, state_d;
	logic       done_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_INIT: begin
				cmd.sweep    = 1'b1;
				cmd.peak_clr = 1'b1;
				if (sts.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					cmd.load     = 1'b1;
					cmd.win_init = 1'b1;
					unique case (op)
						hsa_pkg::OP_CLEAR: state_d = ST_CLEAR;
						hsa_pkg::OP_SPLAT: state_d = ST_WIN;
						hsa_pkg::OP_READ:  state_d = ST_RD0;
						hsa_pkg::OP_NOP:   state_d = ST_FIN;
					endcase
				end
			end
			ST_CLEAR: begin
				cmd.sweep    = 1'b1;
				cmd.peak_clr = 1'b1;
				if (sts.sweep_last) begin
					state_d = ST_FIN;
				end
			end
			ST_WIN: begin
				cmd.win_step = 1'b1;
				if (sts.win_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (sts.pipe_empty) begin
					state_d = ST_FIN;
				end
			end
			ST_RD0: begin
				cmd.rd_cell = 1'b1;
				state_d     = ST_RD1;
			end
			ST_RD1: begin
				cmd.heat_ld = 1'b1;
				state_d     = ST_COL0;
			end
			ST_COL0: begin
				cmd.col_start = 1'b1;
				state_d       = ST_COL;
			end
			ST_COL: begin
				if (sts.col_done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				cmd.out_ld = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_FIN);
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

endmodule

// ===== hdl/heatmap_splat_accumulator_unit.sv =====
// ----------------------------------------------------------------------------
// Heatmap splat accumulator
// Square heat grid with splat, clear and colour read of one cell.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; one result word follows
// on result with done high for one cycle, and the receiver cannot hold it off.
// After reset, busy stays high while the grid memory is swept to zero. In a
// splat the window of (2*SPLAT_RADIUS+1)^2 cells goes through the single
// read-modify-write port of the grid memory one cell a cycle, and then the
// divider pipeline drains. A clear sweeps every cell of the grid memory to
// zero. A read fetches the cell and runs the 8-step colour divider.
// ----------------------------------------------------------------------------
module heatmap_splat_accumulator_unit #(
	parameter int GRID_SIZE    = 256,
	parameter int SPLAT_RADIUS = 15
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  hsa_pkg::item_t   item,
	output logic             busy,
	output logic             done,
	output hsa_pkg::result_t result
);

	hsa_pkg::cmd_t cmd;
	hsa_pkg::sts_t sts;

	// sequencing
	hsa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (item.opcode),
		.sts    (sts),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// grid, pipeline and colour
	hsa_datapath #(
		.GRID_SIZE    (GRID_SIZE),
		.SPLAT_RADIUS (SPLAT_RADIUS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.sts    (sts),
		.result (result)
	);

endmodule

// ===== hdl/hsa_checker.sv =====
// ----------------------------------------------------------------------------
// Heatmap port checker
// Watches the top level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module hsa_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input hsa_pkg::result_t result
);

	// an accepted word keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accepted word");

	// a result word lasts one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// nonzero flag agrees with the reported heat
	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.cell_nonzero == (result.cell_heat != '0)))
		else $error("cell_nonzero disagrees with cell_heat");

	// heat above the peak reads as pure red
	a_over_peak: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.cell_heat > result.peak_value)) |->
		(result.red == hsa_pkg::COL_MAX && result.green == '0 && result.blue == '0))
		else $error("cell above peak not red");

endmodule

bind heatmap_splat_accumulator_unit hsa_checker u_hsa_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

// ===== test/heatmap_splat_accumulator_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Heatmap splat accumulator testbench
// Drives clear, splat, read and no-op words into the unit and checks every
// result word against a cycle-free model of the heat grid and the peak that
// the bench keeps itself. A short directed list covers the grid corners, the
// colour regions and a clear; random words then cluster splats and reads
// around moving hot spots so that heat piles up.
// ----------------------------------------------------------------------------
module heatmap_splat_accumulator_unit_tb;
	import hsa_pkg::*;

	localparam int GRID_N      = 256;
	localparam int SPLAT_R     = 15;
	localparam int RAND_WORDS  = 600;
	localparam int STALL_LIMIT = 300000;
	localparam int TAIL_CYCLES = 40;
	localparam longint BLEND_NUM = 2 * longint'(COL_MAX);

	logic    clk    = 1'b0;
	logic    arst_n = 1'b0;
	logic    start  = 1'b0;
	item_t   item   = '0;
	logic    busy;
	logic    done;
	result_t result;

	heatmap_splat_accumulator_unit #(
		.GRID_SIZE   (GRID_N),
		.SPLAT_RADIUS(SPLAT_R)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.item  (item),
		.busy  (busy),
		.done  (done),
		.result(result)
	);

	always #2 clk = ~clk;

	// bench copy of the grid and the peak
	bit [HEAT_W-1:0] heat_mem [GRID_N*GRID_N];
	bit [HEAT_W-1:0] peak_level;

	item_t   cmd_backlog[$];
	result_t pending_results[$];

	item_t cur_word   = '0;
	bit    holding    = 1'b0;
	bit    word_taken = 1'b0;
	int    words_sent = 0;
	int    quiet_cycles = 0;
	int    mismatches = 0;
	int    results_seen = 0;
	int    n_clear = 0, n_splat = 0, n_read = 0, n_nop = 0;

	function automatic bit on_grid(int c);
		return c >= 0 && c < GRID_N;
	endfunction

	// saturating add into one cell
	function automatic void bump_cell(int idx, int unsigned amt);
		longint s;
		s = longint'(heat_mem[idx]) + longint'(amt);
		heat_mem[idx] = (s > longint'(HEAT_MAX)) ? HEAT_MAX : s[HEAT_W-1:0];
	endfunction

	// centre gets a fixed bump, the rest of the window falls off as 800/d^2
	function automatic void spread_splat(int cx, int cy);
		int ci, cj, d2;
		if (on_grid(cx) && on_grid(cy))
			bump_cell(cx * GRID_N + cy, int'(CENTRE_ADD));
		for (int dx = -SPLAT_R; dx <= SPLAT_R; dx++) begin
			for (int dy = -SPLAT_R; dy <= SPLAT_R; dy++) begin
				ci = cx + dx;
				cj = cy + dy;
				if ((dx != 0 || dy != 0) && on_grid(ci) && on_grid(cj)) begin
					d2 = dx * dx + dy * dy;
					bump_cell(ci * GRID_N + cj, SPREAD_NUM / d2);
				end
			end
		end
		if (on_grid(cx) && on_grid(cy) && heat_mem[cx * GRID_N + cy] > peak_level)
			peak_level = heat_mem[cx * GRID_N + cy];
	endfunction

	// blue-green-red ramp of heat h against peak p
	function automatic void color_of(input longint h, input longint p,
			output logic [COL_W-1:0] r, output logic [COL_W-1:0] g,
			output logic [COL_W-1:0] b);
		longint lvl;
		r = '0;
		g = '0;
		b = '0;
		if (h > p) begin
			r = COL_MAX;
		end else if (2 * h <= p) begin
			lvl = (p == 0) ? 0 : (h * BLEND_NUM) / p;
			if (lvl > longint'(COL_MAX)) lvl = longint'(COL_MAX);
			g = lvl[COL_W-1:0];
			b = COL_MAX - g;
		end else begin
			lvl = ((p - h) * longint'(COL_MAX)) / h;
			if (lvl > longint'(COL_MAX)) lvl = longint'(COL_MAX);
			g = lvl[COL_W-1:0];
			r = COL_MAX - g;
		end
	endfunction

	// apply one word to the bench grid and return the result it must produce
	function automatic result_t predict_heat_result(item_t w);
		result_t r;
		longint  h;
		r = '0;
		h = 0;
		case (w.opcode)
			OP_CLEAR: begin
				foreach (heat_mem[k]) heat_mem[k] = '0;
				peak_level = '0;
			end
			OP_SPLAT: spread_splat(int'(w.pos_x), int'(w.pos_y));
			OP_READ: begin
				if (on_grid(int'(w.pos_x)) && on_grid(int'(w.pos_y)))
					h = heat_mem[int'(w.pos_x) * GRID_N + int'(w.pos_y)];
				r.cell_nonzero = (h != 0);
				r.cell_heat = h[HEAT_W-1:0];
				color_of(h, longint'(peak_level), r.red, r.green, r.blue);
			end
			OP_NOP: ;
		endcase
		r.peak_value = peak_level;
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("MISMATCH result %0d: %s", results_seen, msg);
		mismatches++;
	endtask

	task automatic check_result(result_t got);
		result_t want;
		if (pending_results.size() == 0) begin
			report_mismatch("result word with nothing outstanding");
			return;
		end
		want = pending_results.pop_front();
		if (got.red !== want.red)
			report_mismatch($sformatf("red %0d, expected %0d", got.red, want.red));
		if (got.green !== want.green)
			report_mismatch($sformatf("green %0d, expected %0d", got.green, want.green));
		if (got.blue !== want.blue)
			report_mismatch($sformatf("blue %0d, expected %0d", got.blue, want.blue));
		if (got.cell_nonzero !== want.cell_nonzero)
			report_mismatch($sformatf("cell_nonzero %0b, expected %0b",
				got.cell_nonzero, want.cell_nonzero));
		if (got.cell_heat !== want.cell_heat)
			report_mismatch($sformatf("cell_heat %0d, expected %0d",
				got.cell_heat, want.cell_heat));
		if (got.peak_value !== want.peak_value)
			report_mismatch($sformatf("peak_value %0d, expected %0d",
				got.peak_value, want.peak_value));
	endtask

	task automatic queue_cmd(logic [OP_W-1:0] op, int x, int y);
		item_t w;
		w.opcode = op;
		w.pos_x = x[POS_W-1:0];
		w.pos_y = y[POS_W-1:0];
		cmd_backlog.push_back(w);
	endtask

	// driver: one word held until taken, start dropped at random for gaps;
	// words 260..400 go in with no gaps at all
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (word_taken || !holding) begin
				holding = (cmd_backlog.size() != 0);
				if (holding) begin
					cur_word = cmd_backlog.pop_front();
					words_sent++;
				end
			end
			start <= holding &&
				!((words_sent < 260 || words_sent > 400) && $urandom_range(0, 99) < 14);
			item <= cur_word;
		end
	end

	// monitor: predict on acceptance, check on done, watch for a stall
	always @(posedge clk) begin
		if (!arst_n) begin
			word_taken <= 1'b0;
			quiet_cycles <= 0;
		end else begin
			word_taken <= start && !busy;
			if (done) begin
				check_result(result);
				results_seen++;
			end
			if (start && !busy) begin
				pending_results.push_back(predict_heat_result(item));
				case (item.opcode)
					OP_CLEAR: n_clear++;
					OP_SPLAT: n_splat++;
					OP_READ:  n_read++;
					OP_NOP:   n_nop++;
				endcase
			end
			if ((start && !busy) || done) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin : stimulus
		int hx, hy, roll, px, py;

		// directed: empty grid, corners, colour regions, clear
		queue_cmd(OP_READ, 0, 0);       // zero peak, zero heat: pure blue
		queue_cmd(OP_NOP, 255, 255);
		queue_cmd(OP_SPLAT, 0, 0);      // corner, most of the window off grid
		queue_cmd(OP_READ, 0, 0);       // heat equals peak
		queue_cmd(OP_READ, 1, 0);       // neighbour hotter than the peak
		queue_cmd(OP_READ, 15, 15);     // window corner, low end of the ramp
		queue_cmd(OP_READ, 16, 0);      // just outside the window
		queue_cmd(OP_SPLAT, 255, 255);
		queue_cmd(OP_SPLAT, 0, 255);
		queue_cmd(OP_SPLAT, 255, 0);
		queue_cmd(OP_READ, 255, 240);
		queue_cmd(OP_SPLAT, 128, 128);
		queue_cmd(OP_SPLAT, 128, 128);
		queue_cmd(OP_SPLAT, 130, 128);
		queue_cmd(OP_READ, 128, 128);
		queue_cmd(OP_READ, 129, 128);
		queue_cmd(OP_READ, 143, 143);
		queue_cmd(OP_READ, 128, 113);
		queue_cmd(OP_NOP, 0, 0);
		queue_cmd(OP_CLEAR, 170, 85);
		queue_cmd(OP_READ, 128, 128);   // cleared cell
		queue_cmd(OP_READ, 255, 255);
		queue_cmd(OP_SPLAT, 127, 127);
		queue_cmd(OP_READ, 127, 127);

		// random: splats and reads clustered on a hot spot that moves
		hx = 0;
		hy = 0;
		for (int k = 0; k < RAND_WORDS; k++) begin
			if (k % 45 == 0) begin
				if ($urandom_range(0, 3) == 0) begin
					hx = $urandom_range(0, 1) ? $urandom_range(0, 8) : $urandom_range(247, 255);
					hy = $urandom_range(0, 1) ? $urandom_range(0, 8) : $urandom_range(247, 255);
				end else begin
					hx = $urandom_range(0, 255);
					hy = $urandom_range(0, 255);
				end
			end
			roll = $urandom_range(0, 99);
			if (k == 200 || k == 430) begin
				queue_cmd(OP_CLEAR, $urandom_range(0, 255), $urandom_range(0, 255));
			end else if (roll < 38) begin
				px = hx + $urandom_range(0, 12) - 6;
				py = hy + $urandom_range(0, 12) - 6;
				queue_cmd(OP_SPLAT, px, py);
			end else if (roll < 45) begin
				queue_cmd(OP_SPLAT, $urandom_range(0, 255), $urandom_range(0, 255));
			end else if (roll < 85) begin
				px = hx + $urandom_range(0, 34) - 17;
				py = hy + $urandom_range(0, 34) - 17;
				queue_cmd(OP_READ, px, py);
			end else if (roll < 93) begin
				queue_cmd(OP_READ, $urandom_range(0, 255), $urandom_range(0, 255));
			end else if (roll < 97) begin
				queue_cmd(OP_NOP, $urandom_range(0, 255), $urandom_range(0, 255));
			end else begin
				// grid border
				px = $urandom_range(0, 1) ? 255 : 0;
				queue_cmd(OP_READ, px, $urandom_range(0, 255));
			end
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (cmd_backlog.size() != 0 || holding || pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d splats, %0d reads, %0d clears, %0d no-ops",
			n_splat, n_read, n_clear, n_nop);
		$display("%0d result words checked, final peak %0d, %0d mismatches",
			results_seen, peak_level, mismatches);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
